@@ rtl/core/tsc_interpolated_tick_accounting_macros.svh @@
// Assertion macros shared by the tick accounting RTL.
`ifndef TSC_INTERPOLATED_TICK_ACCOUNTING_MACROS_SVH
`define TSC_INTERPOLATED_TICK_ACCOUNTING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSC_ITA_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSC_ITA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/core/tsc_ita_pkg.sv @@
package tsc_ita_pkg;

   localparam int HOST_TIME_WIDTH = 64;
   localparam int CYCLE_WIDTH     = 32;
   localparam int TICK_FIELD_WIDTH = 32;
   localparam int QUOTIENT_WIDTH  = 32;
   localparam int TICK_LEN_WIDTH  = 30;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USEC_QUOTIENT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICK_LENGTH   = 1'd1;

   localparam logic [QUOTIENT_WIDTH-1:0] QUOTIENT_RESET = 32'd4294967;
   localparam logic [TICK_LEN_WIDTH-1:0] TICK_LEN_RESET = 30'd10000000;

   localparam logic [QUOTIENT_WIDTH-1:0] NS_PER_USEC = 32'd1000;

   localparam logic COMMAND_TICK   = 1'b0;
   localparam logic COMMAND_RESYNC = 1'b1;

   localparam int TICK_COUNT_WIDTH_DEFAULT = 32;

endpackage

@@ rtl/core/tsc_ita_req_if.sv @@
interface tsc_ita_req_if;

   logic                                      valid;
   logic                                      ready;
   logic                                      command;
   logic [tsc_ita_pkg::HOST_TIME_WIDTH-1:0]   host_system_time_ns;
   logic [tsc_ita_pkg::CYCLE_WIDTH-1:0]       cycle_stamp;
   logic [tsc_ita_pkg::CYCLE_WIDTH-1:0]       cycle_now;

   modport source (
      output valid, command, host_system_time_ns, cycle_stamp, cycle_now,
      input  ready
   );

   modport sink (
      input  valid, command, host_system_time_ns, cycle_stamp, cycle_now,
      output ready
   );

endinterface

@@ rtl/core/tsc_ita_rsp_if.sv @@
interface tsc_ita_rsp_if;

   logic                                      valid;
   logic                                      ready;
   logic [tsc_ita_pkg::TICK_FIELD_WIDTH-1:0]  elapsed_ticks;
   logic                                      fire_clock;
   logic                                      went_backwards;
   logic [tsc_ita_pkg::HOST_TIME_WIDTH-1:0]   next_deadline_ns;

   modport source (
      output valid, elapsed_ticks, fire_clock, went_backwards, next_deadline_ns,
      input  ready
   );

   modport sink (
      input  valid, elapsed_ticks, fire_clock, went_backwards, next_deadline_ns,
      output ready
   );

endinterface

@@ rtl/core/tsc_interpolated_tick_accounting.sv @@
// Channel    Direction  Handshake      Carries
// req_chan   in         valid/ready    command, host time, cycle stamp, cycle now
// rsp_chan   out        valid/ready    elapsed ticks, fire, backwards, deadline
// csr_*      in         write enable   quotient and tick length registers
//
// A tick event runs two multiplies, two adds, 64 restoring division steps and
// two closing adds on one shared adder; backwards time or a zero tick length
// skips the division and first closing add. A resync goes straight to the result.
// The block takes one item at a time and is busy until its result is loaded.
// Reset is synchronous; it clears the processed time and restores both registers.
// A result waits in the output register while the next item is taken.
`include "tsc_interpolated_tick_accounting_macros.svh"

module tsc_interpolated_tick_accounting #(
   parameter int TICK_COUNT_WIDTH = tsc_ita_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   tsc_ita_req_if.sink                             req_chan,
   tsc_ita_rsp_if.source                           rsp_chan,
   input  logic                                    csr_we,
   input  logic [tsc_ita_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tsc_ita_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int TW = tsc_ita_pkg::HOST_TIME_WIDTH;
   localparam int CW = tsc_ita_pkg::CYCLE_WIDTH;
   localparam int QW = tsc_ita_pkg::QUOTIENT_WIDTH;
   localparam int LW = tsc_ita_pkg::TICK_LEN_WIDTH;
   localparam int FW = tsc_ita_pkg::TICK_FIELD_WIDTH;

   localparam int LIM_W = (TICK_COUNT_WIDTH < FW) ? TICK_COUNT_WIDTH : FW;
   localparam logic [TW-1:0] TICK_LIMIT = (64'd1 << LIM_W) - 64'd1;

   localparam int DIV_CNT_W = $clog2(TW);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TW - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_STEP = DIV_CNT_W'(1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL1 = 4'd1;
   localparam logic [3:0] S_MUL2 = 4'd2;
   localparam logic [3:0] S_SUM  = 4'd3;
   localparam logic [3:0] S_DIFF = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_FIX  = 4'd6;
   localparam logic [3:0] S_DONE = 4'd7;

   logic [3:0]           state_ff, state_in;
   logic [QW-1:0]        quotient_ff;
   logic [LW-1:0]        tick_len_ff;
   logic [TW-1:0]        processed_ff, processed_in;
   logic [TW-1:0]        host_ff, host_in;
   logic [CW-1:0]        cyc_ff, cyc_in;
   logic [TW-1:0]        prod_ff, prod_in;
   logic [TW-1:0]        sum_ff, sum_in;
   logic [TW-1:0]        div_ff, div_in;
   logic [LW-1:0]        rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 back_ff, back_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]        rsp_elapsed_ff;
   logic                 rsp_fire_ff;
   logic                 rsp_back_ff;
   logic [TW-1:0]        rsp_deadline_ff;

   logic [QW-1:0]        mul_a, mul_b;
   logic [2*QW-1:0]      mul_res;
   logic [TW-1:0]        add_a, add_b, add_res;
   logic                 add_sub;

   logic                 req_xfer;
   logic                 out_load;
   logic [FW-1:0]        elapsed;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.elapsed_ticks    = rsp_elapsed_ff;
   assign rsp_chan.fire_clock       = rsp_fire_ff;
   assign rsp_chan.went_backwards   = rsp_back_ff;
   assign rsp_chan.next_deadline_ns = rsp_deadline_ff;

   assign elapsed = (div_ff > TICK_LIMIT) ? TICK_LIMIT[FW-1:0] : div_ff[FW-1:0];

   // Shared multiplier.
   always_comb begin
      mul_a = cyc_ff;
      mul_b = quotient_ff;
      if (state_ff == S_MUL2) begin
         mul_a = prod_ff[2*QW-1:QW];
         mul_b = tsc_ita_pkg::NS_PER_USEC;
      end
   end

   assign mul_res = mul_a * mul_b;

   // Shared adder and subtractor.
   always_comb begin
      add_a   = sum_ff;
      add_b   = processed_ff;
      add_sub = 1'b1;
      case (state_ff)
         S_SUM: begin
            add_a   = host_ff;
            add_b   = prod_ff;
            add_sub = 1'b0;
         end
         S_DIFF: begin
            add_a   = sum_ff;
            add_b   = processed_ff;
            add_sub = 1'b1;
         end
         S_DIV: begin
            add_a   = {{(TW-LW-1){1'b0}}, rem_ff, div_ff[TW-1]};
            add_b   = {{(TW-LW){1'b0}}, tick_len_ff};
            add_sub = 1'b1;
         end
         S_FIX: begin
            add_a   = sum_ff;
            add_b   = {{(TW-LW){1'b0}}, rem_ff};
            add_sub = 1'b1;
         end
         S_DONE: begin
            add_a   = processed_ff;
            add_b   = {{(TW-LW){1'b0}}, tick_len_ff};
            add_sub = 1'b0;
         end
         default: begin
            add_a   = sum_ff;
            add_b   = processed_ff;
            add_sub = 1'b1;
         end
      endcase
   end

   assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      processed_in = processed_ff;
      host_in      = host_ff;
      cyc_in       = cyc_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      back_in      = back_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               host_in = req_chan.host_system_time_ns;
               cyc_in  = req_chan.cycle_now - req_chan.cycle_stamp;
               back_in = 1'b0;
               div_in  = '0;
               if (req_chan.command == tsc_ita_pkg::COMMAND_RESYNC) begin
                  processed_in = req_chan.host_system_time_ns;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            prod_in  = mul_res;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in  = mul_res;
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in   = add_res;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            rem_in = '0;
            cnt_in = '0;
            if (add_res[TW-1]) begin
               back_in  = 1'b1;
               div_in   = '0;
               state_in = S_DONE;
            end else if (tick_len_ff == '0) begin
               div_in   = '0;
               state_in = S_DONE;
            end else begin
               div_in   = add_res;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!add_res[TW-1]) begin
               rem_in = add_res[LW-1:0];
               div_in = {div_ff[TW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[LW-2:0], div_ff[TW-1]};
               div_in = {div_ff[TW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + DIV_STEP;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            processed_in = add_res;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         processed_ff <= '0;
         rsp_valid_ff <= 1'b0;
         quotient_ff  <= tsc_ita_pkg::QUOTIENT_RESET;
         tick_len_ff  <= tsc_ita_pkg::TICK_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         processed_ff <= processed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               tsc_ita_pkg::CSR_USEC_QUOTIENT: quotient_ff <= csr_wdata[QW-1:0];
               tsc_ita_pkg::CSR_TICK_LENGTH:   tick_len_ff <= csr_wdata[LW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      host_ff <= host_in;
      cyc_ff  <= cyc_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      back_ff <= back_in;
      if (out_load) begin
         rsp_elapsed_ff  <= elapsed;
         rsp_fire_ff     <= (elapsed != '0);
         rsp_back_ff     <= back_ff;
         rsp_deadline_ff <= add_res;
      end
   end

   `TSC_ITA_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_xfer, !req_chan.ready,
      "block still ready after taking an item")
   `TSC_ITA_ASSERT_SAME(a_backwards_no_ticks, clock, reset,
      rsp_chan.valid && rsp_chan.went_backwards,
      rsp_chan.elapsed_ticks == '0 && !rsp_chan.fire_clock,
      "ticks reported on a backwards result")
   `TSC_ITA_ASSERT_SAME(a_fire_matches_ticks, clock, reset, rsp_chan.valid,
      rsp_chan.fire_clock == (rsp_chan.elapsed_ticks != '0),
      "fire flag disagrees with tick count")
   `TSC_ITA_ASSERT_NEXT(a_processed_held, clock, reset,
      state_ff != S_FIX && !req_xfer, $stable(processed_ff),
      "processed time moved outside an update")

endmodule

@@ test/tick_accounting_checker.sv @@
`timescale 1ns / 1ps

module tick_accounting_checker #(
   parameter int TICK_COUNT_WIDTH = tsc_ita_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   tsc_ita_req_if                                  req_mon,
   tsc_ita_rsp_if                                  rsp_mon,
   input  logic                                    csr_we,
   input  logic [tsc_ita_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tsc_ita_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                      pending,
   output int                                      failures
);

   import tsc_ita_pkg::*;

   typedef struct packed {
      logic [TICK_FIELD_WIDTH-1:0] elapsed_ticks;
      logic                        fire_clock;
      logic                        went_backwards;
      logic [HOST_TIME_WIDTH-1:0]  next_deadline_ns;
   } tick_outcome_type;

   localparam logic [63:0] WIDTH_LIMIT =
      (TICK_COUNT_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                               : ((64'd1 << TICK_COUNT_WIDTH) - 64'd1);
   localparam logic [63:0] TICK_LIMIT =
      (WIDTH_LIMIT > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : WIDTH_LIMIT;

   logic [QUOTIENT_WIDTH-1:0]  quotient;
   logic [TICK_LEN_WIDTH-1:0]  tick_len;
   logic [HOST_TIME_WIDTH-1:0] processed_ns;
   tick_outcome_type           predicted_outcomes[$];
   int                         mismatches = 0;

   assign failures = mismatches;

   function automatic tick_outcome_type account_event(
      input logic                       command,
      input logic [HOST_TIME_WIDTH-1:0] host,
      input logic [CYCLE_WIDTH-1:0]     stamp,
      input logic [CYCLE_WIDTH-1:0]     now
   );
      logic [CYCLE_WIDTH-1:0] cycles;
      logic [63:0]            usec;
      logic [63:0]            diff;
      logic [63:0]            ticks;
      logic [63:0]            len;
      tick_outcome_type       outcome;
      outcome = '0;
      len = 64'(tick_len);
      if (command == COMMAND_RESYNC) begin
         processed_ns = host;
      end else begin
         cycles = now - stamp;
         usec   = (64'(cycles) * 64'(quotient)) >> 32;
         diff   = host + usec * 64'(NS_PER_USEC) - processed_ns;
         if (diff[63]) begin
            outcome.went_backwards = 1'b1;
         end else if (len != 64'd0) begin
            ticks        = diff / len;
            processed_ns = processed_ns + ticks * len;
            outcome.elapsed_ticks = (ticks > TICK_LIMIT) ? TICK_LIMIT[31:0] : ticks[31:0];
         end
      end
      outcome.fire_clock       = (outcome.elapsed_ticks != '0);
      outcome.next_deadline_ns = processed_ns + len;
      return outcome;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      tick_outcome_type want;
      if (reset) begin
         quotient     = QUOTIENT_RESET;
         tick_len     = TICK_LEN_RESET;
         processed_ns = '0;
         predicted_outcomes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_outcomes.size() == 0) begin
               $error("result transfer with no outstanding prediction");
               mismatches++;
            end else begin
               want = predicted_outcomes.pop_front();
               check_field("elapsed_ticks", 64'(want.elapsed_ticks),
                           64'(rsp_mon.elapsed_ticks));
               check_field("fire_clock", 64'(want.fire_clock), 64'(rsp_mon.fire_clock));
               check_field("went_backwards", 64'(want.went_backwards),
                           64'(rsp_mon.went_backwards));
               check_field("next_deadline_ns", want.next_deadline_ns,
                           rsp_mon.next_deadline_ns);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_USEC_QUOTIENT: begin
                  quotient = csr_wdata;
               end
               CSR_TICK_LENGTH: begin
                  tick_len = csr_wdata[TICK_LEN_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predicted_outcomes.push_back(account_event(req_mon.command,
               req_mon.host_system_time_ns, req_mon.cycle_stamp, req_mon.cycle_now));
         end
      end
      pending <= predicted_outcomes.size();
   end

endmodule

@@ test/tb_tsc_interpolated_tick_accounting.sv @@
`timescale 1ns / 1ps

module tb_tsc_interpolated_tick_accounting;

   import tsc_ita_pkg::*;

   localparam int DRAIN_LIMIT   = 100000;
   localparam int PHASE_ITEMS   = 205;
   localparam int HOLD_AFTER    = 300;
   localparam int HOLD_CYCLES   = 500;
   localparam int SETTLE_CYCLES = 80;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   int pending_results;
   int mismatch_count;
   int results_seen;
   int items_sent;
   int resyncs_sent;
   int settings_applied;

   logic [QUOTIENT_WIDTH-1:0]  cur_quot;
   logic [TICK_LEN_WIDTH-1:0]  cur_len;
   logic [HOST_TIME_WIDTH-1:0] wall_ns;

   tsc_ita_req_if req_bus ();
   tsc_ita_rsp_if rsp_bus ();

   tsc_interpolated_tick_accounting uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tick_accounting_checker checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_bus),
      .rsp_mon   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending_results),
      .failures  (mismatch_count)
   );

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   initial results_seen = 0;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen <= results_seen + 1;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 3);
      end else if (r < 96) begin
         return $urandom_range(4, 20);
      end
      return $urandom_range(40, 150);
   endfunction

   // Receiver: random stalls in windows that switch idling on and off, and one
   // long hold-off so that the block backs up onto its input.
   initial begin
      int stall;
      int window;
      bit idle_on;
      bit hold_done;
      stall     = 0;
      window    = 0;
      idle_on   = 1'b1;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (window == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
            window  = 300;
         end
         window--;
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) begin
               stall = gap_length();
            end
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [63:0] host,
                            input logic [31:0] stamp, input logic [31:0] now);
      int gap;
      gap = 0;
      if ((items_sent % 128) < 100 && $urandom_range(0, 9) < 4) begin
         gap = gap_length();
      end
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.command             <= cmd;
      req_bus.host_system_time_ns <= host;
      req_bus.cycle_stamp         <= stamp;
      req_bus.cycle_now           <= now;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (cmd == COMMAND_RESYNC) begin
         resyncs_sent++;
      end
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results != 0) begin
         @(negedge clock);
         waited++;
         if (waited > DRAIN_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   endtask

   task automatic apply_setting(input logic [31:0] quot, input logic [29:0] len);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_USEC_QUOTIENT;
      csr_wdata <= quot;
      @(negedge clock);
      csr_index <= CSR_TICK_LENGTH;
      csr_wdata <= 32'(len);
      @(negedge clock);
      csr_we <= 1'b0;
      cur_quot = quot;
      cur_len  = len;
      settings_applied++;
   endtask

   // Mostly a steadily advancing host clock with short cycle deltas, plus
   // resyncs, late stamps that run backwards and fully random transfers.
   task automatic random_item();
      int          pick;
      logic [63:0] host;
      logic [63:0] span;
      logic [31:0] stamp;
      logic [31:0] now;
      pick  = $urandom_range(0, 99);
      stamp = $urandom;
      now   = stamp + $urandom_range(0, 50000);
      span  = (cur_len == '0) ? 64'd1_000_000 : 64'(cur_len);
      if (pick < 8) begin
         host    = (pick < 2) ? {$urandom, $urandom} : wall_ns + span * 64'($urandom_range(0, 3));
         wall_ns = host;
         send_item(COMMAND_RESYNC, host, stamp, now);
      end else if (pick < 16) begin
         send_item(1'($urandom), {$urandom, $urandom}, $urandom, $urandom);
      end else if (pick < 24) begin
         host = wall_ns - 64'($urandom_range(0, 32'(span)));
         send_item(COMMAND_TICK, host, stamp, now);
      end else begin
         wall_ns = wall_ns + span * 64'($urandom_range(0, 4))
                   + 64'($urandom_range(0, 32'(span)));
         send_item(COMMAND_TICK, wall_ns, stamp, now);
      end
   endtask

   initial begin
      logic [31:0] quot;
      logic [29:0] len;
      req_bus.valid               = 1'b0;
      req_bus.command             = COMMAND_TICK;
      req_bus.host_system_time_ns = '0;
      req_bus.cycle_stamp         = '0;
      req_bus.cycle_now           = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_USEC_QUOTIENT;
      csr_wdata        = '0;
      reset            = 1'b1;
      items_sent       = 0;
      resyncs_sent     = 0;
      settings_applied = 0;
      cur_quot         = QUOTIENT_RESET;
      cur_len          = TICK_LEN_RESET;
      wall_ns          = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset register values first.
      send_item(COMMAND_TICK, 64'd0, 32'd0, 32'd0);
      send_item(COMMAND_TICK, 64'd35_000_000, 32'h10, 32'h10 + 32'd5000);
      send_item(COMMAND_TICK, 64'd1000, 32'd0, 32'd0);
      send_item(COMMAND_RESYNC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_item(COMMAND_TICK, 64'd0, 32'hFFFF_FFFF, 32'h0);
      send_item(COMMAND_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      send_item(COMMAND_RESYNC, 64'd0, 32'h0, 32'h0);
      send_item(COMMAND_TICK, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
      send_item(COMMAND_RESYNC, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(COMMAND_TICK, 64'h8000_0000_0000_0000, 32'h0, 32'h0);

      // Largest multiplier with a one nanosecond tick saturates the count.
      apply_setting(32'hFFFF_FFFF, 30'd1);
      send_item(COMMAND_RESYNC, 64'd0, 32'h0, 32'h0);
      send_item(COMMAND_TICK, 64'd0, 32'h0, 32'hFFFF_FFFF);
      send_item(COMMAND_TICK, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA, 32'hAAAA_5555);

      // A zero tick length accounts nothing but still reports backwards time.
      apply_setting(32'h0, 30'd0);
      send_item(COMMAND_RESYNC, 64'd0, 32'h0, 32'h0);
      send_item(COMMAND_TICK, 64'd5_000_000, 32'h1234, 32'h9876);
      send_item(COMMAND_TICK, 64'd0, 32'h0, 32'h0);
      send_item(COMMAND_RESYNC, 64'd100, 32'h0, 32'h0);
      send_item(COMMAND_TICK, 64'd50, 32'h0, 32'h0);

      apply_setting(QUOTIENT_RESET, 30'd1_000_000_000);
      send_item(COMMAND_RESYNC, 64'd0, 32'h0, 32'h0);
      send_item(COMMAND_TICK, 64'd2_999_999_999, 32'h100, 32'h200);
      send_item(COMMAND_TICK, 64'd3_000_000_000, 32'h0, 32'd1000);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               quot = QUOTIENT_RESET;
               len  = TICK_LEN_RESET;
            end
            1: begin
               quot = 32'hFFFF_FFFF;
               len  = 30'd1;
            end
            2: begin
               quot = $urandom;
               len  = 30'($urandom_range(1, 1_000_000_000));
            end
            3: begin
               quot = 32'h0;
               len  = 30'd1_000_000_000;
            end
            4: begin
               quot = $urandom;
               len  = 30'($urandom_range(1, 5000));
            end
            default: begin
               quot = $urandom;
               len  = 30'd0;
            end
         endcase
         apply_setting(quot, len);
         send_item(COMMAND_RESYNC, wall_ns, $urandom, $urandom);
         repeat (PHASE_ITEMS) random_item();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d items, %0d of them resyncs, under %0d register settings.",
               items_sent, resyncs_sent, settings_applied);
      $display("Checked %0d results, including a long receiver hold-off.", results_seen);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
